// File: rtl/bsp_pkg.sv
// Shared constants, types and a helper function for the billboard sprite projection block.
package bsp_pkg;

  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 768;
  localparam int HALF_W        = SCREEN_WIDTH / 2;
  localparam int HALF_H        = SCREEN_HEIGHT / 2;

  localparam int NUM_W      = 48;
  localparam int DEN_W      = 38;
  localparam int DIV_STAGES = NUM_W;
  localparam int PIPE_DEPTH = DIV_STAGES + 6;

  localparam logic [15:0] SPRITE_X_RESET = 16'd1152;
  localparam logic [15:0] SPRITE_Y_RESET = 16'd384;

  typedef enum logic {
    REG_SPRITE_POS_X = 1'b0,
    REG_SPRITE_POS_Y = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic neg_depth;
    logic neg_centre;
    logic singular;
    logic ny_zero;
    logic nx_pos;
    logic nx_neg;
  } side_t;

  function automatic logic [11:0] clamp12(input logic signed [49:0] v,
                                          input logic [11:0] hi);
    logic [11:0] r;
    if (v < 0) begin
      r = 12'd0;
    end else if (v > $signed({38'd0, hi})) begin
      r = hi;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/bsp_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
module bsp_div
  import bsp_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [DEN_W-1:0] rem [DIV_STAGES];
  logic [NUM_W-1:0] nq  [DIV_STAGES];
  logic [DEN_W-1:0] dd  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DEN_W-1:0] r_prev;
    logic [NUM_W-1:0] nq_prev;
    logic [DEN_W-1:0] d_prev;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign r_prev  = '0;
      assign nq_prev = num;
      assign d_prev  = den;
    end else begin : g_next
      assign r_prev  = rem[k-1];
      assign nq_prev = nq[k-1];
      assign d_prev  = dd[k-1];
    end

    assign trial = {r_prev, nq_prev[NUM_W-1]};
    assign ge    = trial >= {1'b0, d_prev};
    assign diff  = trial - {1'b0, d_prev};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq[k]  <= {nq_prev[NUM_W-2:0], ge};
        dd[k]  <= d_prev;
      end
    end
  end

  assign quo = nq[DIV_STAGES-1];

endmodule

// File: rtl/billboard_sprite_projection_top.sv
// Top level of the billboard sprite projection pipeline.
//
//   channel | direction | handshake           | beat
//   in      | input     | in_valid / in_stall | player position, view and plane vectors
//   out     | output    | out_valid/out_stall | column, size, extents, depth, flags
//   cfg     | input     | cfg_valid/cfg_ready | register index and write data
//
// One beat enters per cycle while the output is not stalled. Each result passes the offset,
// product, determinant, operand, divider, sign and output stages in that order.
// Most of the depth lies in the three 48-stage dividers, one quotient bit per stage.
// Reset clears the valid bits and loads the default sprite position.
// A stalled output freezes the whole pipeline, so in_stall follows it.
module billboard_sprite_projection_top
  import bsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        player_x,
  input  logic [15:0]        player_y,
  input  logic signed [15:0] view_dir_x,
  input  logic signed [15:0] view_dir_y,
  input  logic signed [15:0] cam_plane_x,
  input  logic signed [15:0] cam_plane_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] center_column,
  output logic [15:0]        sprite_size,
  output logic [11:0]        first_row,
  output logic [11:0]        last_row,
  output logic [11:0]        first_column,
  output logic [11:0]        last_column,
  output logic signed [15:0] depth,
  output logic               behind_camera,
  output logic               singular_camera,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  cfg_reg_t           cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [15:0] sprite_x;
  logic [15:0] sprite_y;
  logic [PIPE_DEPTH-1:0] vld;
  logic en;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_x <= SPRITE_X_RESET;
      sprite_y <= SPRITE_Y_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SPRITE_POS_X: sprite_x <= cfg_data;
        REG_SPRITE_POS_Y: sprite_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // Stage 1: offsets, with x and y crossed.
  logic signed [16:0] off_x, off_y;
  logic signed [15:0] dx1, dy1, qx1, qy1;

  always_ff @(posedge clk) begin
    if (en) begin
      off_x <= $signed({1'b0, sprite_y}) - $signed({1'b0, player_y});
      off_y <= $signed({1'b0, sprite_x}) - $signed({1'b0, player_x});
      dx1   <= view_dir_x;
      dy1   <= view_dir_y;
      qx1   <= cam_plane_x;
      qy1   <= cam_plane_y;
    end
  end

  // Stage 2: products.
  logic signed [31:0] m_qxdy, m_dxqy;
  logic signed [32:0] m_dyox, m_dxoy, m_qxoy, m_qyox;

  always_ff @(posedge clk) begin
    if (en) begin
      m_qxdy <= 32'(qx1) * 32'(dy1);
      m_dxqy <= 32'(dx1) * 32'(qy1);
      m_dyox <= 33'(dy1) * 33'(off_x);
      m_dxoy <= 33'(dx1) * 33'(off_y);
      m_qxoy <= 33'(qx1) * 33'(off_y);
      m_qyox <= 33'(qy1) * 33'(off_x);
    end
  end

  // Stage 3: determinant and camera-space numerators.
  logic signed [32:0] det;
  logic signed [33:0] nx, ny;

  always_ff @(posedge clk) begin
    if (en) begin
      det <= $signed({m_qxdy[31], m_qxdy}) - $signed({m_dxqy[31], m_dxqy});
      nx  <= $signed({m_dyox[32], m_dyox}) - $signed({m_dxoy[32], m_dxoy});
      ny  <= $signed({m_qxoy[32], m_qxoy}) - $signed({m_qyox[32], m_qyox});
    end
  end

  // Stage 4: magnitudes and divider operands.
  logic signed [34:0] sum_c;
  logic [32:0] det_neg, ny_neg;
  logic [34:0] sum_neg;
  logic [31:0] det_abs, ny_abs;
  logic [33:0] sum_abs;
  logic [NUM_W-1:0] num_depth, num_centre, num_size;
  logic [DEN_W-1:0] den_depth, den_centre, den_size;
  side_t side4;

  always_comb begin
    sum_c   = $signed({nx[33], nx}) + $signed({ny[33], ny});
    det_neg = -det;
    ny_neg  = 33'(-ny);
    sum_neg = -sum_c;
    det_abs = det[32] ? det_neg[31:0] : det[31:0];
    ny_abs  = ny[33] ? ny_neg[31:0] : ny[31:0];
    sum_abs = sum_c[34] ? sum_neg[33:0] : sum_c[33:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_depth        <= NUM_W'(ny_abs) << 14;
      den_depth        <= DEN_W'(det_abs);
      num_centre       <= NUM_W'(sum_abs) * NUM_W'(HALF_W);
      den_centre       <= DEN_W'(ny_abs);
      num_size         <= NUM_W'(det_abs) * NUM_W'(SCREEN_HEIGHT);
      den_size         <= DEN_W'(ny_abs) << 6;
      side4.neg_depth  <= ny[33] ^ det[32];
      side4.neg_centre <= sum_c[34] ^ ny[33];
      side4.singular   <= det == '0;
      side4.ny_zero    <= ny == '0;
      side4.nx_pos     <= !nx[33] && (nx != '0);
      side4.nx_neg     <= nx[33];
    end
  end

  logic [NUM_W-1:0] q_depth, q_centre, q_size;

  bsp_div u_div_depth (.clk(clk), .en(en), .num(num_depth), .den(den_depth), .quo(q_depth));
  bsp_div u_div_centre (.clk(clk), .en(en), .num(num_centre), .den(den_centre),
                        .quo(q_centre));
  bsp_div u_div_size (.clk(clk), .en(en), .num(num_size), .den(den_size), .quo(q_size));

  side_t side_d [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side4;
      for (int i = 1; i < DIV_STAGES; i++) begin
        side_d[i] <= side_d[i-1];
      end
    end
  end

  // Stage after the dividers: signs and special cases.
  side_t sd;
  logic signed [15:0] depth_c;
  logic signed [48:0] centre_c;
  logic [NUM_W-1:0] size_c;
  logic signed [15:0] depth_p;
  logic signed [48:0] centre_p;
  logic [NUM_W-1:0] size_p;
  logic singular_p;

  always_comb begin
    sd = side_d[DIV_STAGES-1];
    if (sd.singular) begin
      depth_c  = '0;
      centre_c = 49'(HALF_W);
      size_c   = '0;
    end else if (sd.ny_zero) begin
      depth_c  = '0;
      size_c   = NUM_W'(65535);
      if (sd.nx_pos) begin
        centre_c = 49'sd32767;
      end else if (sd.nx_neg) begin
        centre_c = -49'sd32768;
      end else begin
        centre_c = 49'(HALF_W);
      end
    end else begin
      if (sd.neg_depth) begin
        depth_c = (q_depth > NUM_W'(32768)) ? -16'sd32768 : 16'(-q_depth);
      end else begin
        depth_c = (q_depth > NUM_W'(32767)) ? 16'sd32767 : 16'(q_depth);
      end
      centre_c = sd.neg_centre ? -$signed({1'b0, q_centre}) : $signed({1'b0, q_centre});
      size_c   = q_size;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      depth_p    <= depth_c;
      centre_p   <= centre_c;
      size_p     <= size_c;
      singular_p <= sd.singular;
    end
  end

  // Output stage: extents and saturation.
  logic [NUM_W-1:0] half;
  logic signed [49:0] half_s, centre_s, row_lo, row_hi, col_lo, col_hi;

  always_comb begin
    half     = size_p >> 1;
    half_s   = $signed({2'b00, half});
    centre_s = $signed({centre_p[48], centre_p});
    row_lo   = $signed(50'(HALF_H)) - half_s;
    row_hi   = $signed(50'(HALF_H)) + half_s;
    col_lo   = centre_s - half_s;
    col_hi   = centre_s + half_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (centre_p > 49'sd32767) begin
        center_column <= 16'sd32767;
      end else if (centre_p < -49'sd32768) begin
        center_column <= -16'sd32768;
      end else begin
        center_column <= centre_p[15:0];
      end
      sprite_size     <= (size_p > NUM_W'(65535)) ? 16'hFFFF : size_p[15:0];
      first_row       <= clamp12(row_lo, 12'd4095);
      last_row        <= clamp12(row_hi, 12'(SCREEN_HEIGHT - 1));
      first_column    <= clamp12(col_lo, 12'd4095);
      last_column     <= clamp12(col_hi, 12'(SCREEN_WIDTH - 1));
      depth           <= depth_p;
      behind_camera   <= depth_p <= 16'sd0;
      singular_camera <= singular_p;
    end
  end

`ifndef NO_ASSERTIONS
  a_singular_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular_camera |-> behind_camera && sprite_size == 16'd0 && depth == 16'sd0)
    else $error("singular camera result has inconsistent fields");

  a_stall_follows_output: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not match a held output");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_row <= 12'(SCREEN_HEIGHT - 1) && last_column <= 12'(SCREEN_WIDTH - 1))
    else $error("row or column bound beyond the screen");
`endif

endmodule
